// ===== rtl/ascii_number_parser_core_macros.svh =====
// Assertion macros for the parser RTL, included by the accumulator.
`ifndef ASCII_NUMBER_PARSER_CORE_MACROS_SVH
`define ASCII_NUMBER_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define ANP_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define ANP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/anp_pkg.sv =====
// Types and constants shared by the ASCII number parser.
package anp_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_BITS = 1;
  localparam int QUEUE_CNT_BITS = 2;

  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_ZERO  = 3'd1;
  localparam logic [2:0] MODE_HEX   = 3'd2;
  localparam logic [2:0] MODE_NEG   = 3'd3;
  localparam logic [2:0] MODE_POS   = 3'd4;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;

  typedef struct packed {
    logic       last;
    logic       is_dec;
    logic       is_hex;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
    logic [3:0] digit;
  } anp_item_t;

endpackage

// ===== rtl/anp_front.sv =====
// Character classifier: decodes each incoming character into a parser item.
module anp_front (
  input  logic [7:0]        ch,
  input  logic              last,
  output anp_pkg::anp_item_t item
);
  import anp_pkg::*;

  logic dec_hit;
  logic letter_hit;

  always_comb begin
    dec_hit    = ch inside {[8'h30:8'h39]};
    letter_hit = ch inside {[8'h41:8'h46], [8'h61:8'h66]};
    item.last     = last;
    item.is_dec   = dec_hit;
    item.is_hex   = dec_hit | letter_hit;
    item.is_minus = (ch == CH_MINUS);
    item.is_zero  = (ch == CH_ZERO);
    item.is_x     = (ch == CH_X);
    item.digit    = dec_hit ? ch[3:0] : ch[3:0] + HEX_LETTER_OFFSET;
  end

endmodule

// ===== rtl/anp_queue.sv =====
// Two-entry queue between the classifier and the accumulator.
module anp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  anp_pkg::anp_item_t push_item,
  output logic               not_full,
  input  logic               pop,
  output logic               not_empty,
  output anp_pkg::anp_item_t pop_item
);
  import anp_pkg::*;

  anp_item_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;
  logic                      do_push;
  logic                      do_pop;

  assign not_full  = (count != QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push & not_full;
  assign do_pop    = pop & not_empty;
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/anp_back.sv =====
// Accumulator: runs the parse modes and registers the finished value.
`include "ascii_number_parser_core_macros.svh"

module anp_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  anp_pkg::anp_item_t q_item,
  output logic               pop,
  output logic               value_valid,
  input  logic               value_ready,
  output logic [31:0]        value
);
  import anp_pkg::*;

  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] acc_next;
  logic [2:0]            mode;
  logic [2:0]            mode_next;
  logic                  stopped;
  logic                  stopped_next;
  logic [VALUE_BITS-1:0] acc_in;
  logic                  stop_in;
  logic [VALUE_BITS-1:0] dec_acc;
  logic [VALUE_BITS-1:0] hex_acc;
  logic                  take_dec;
  logic                  take_hex;
  logic signed [VALUE_BITS-1:0] result;

  assign pop = q_valid & (~value_valid | value_ready);

  always_comb begin
    acc_in  = (mode == MODE_START) ? '0 : acc;
    stop_in = (mode == MODE_START) ? 1'b0 : stopped;
    dec_acc = (acc_in << 3) + (acc_in << 1) + VALUE_BITS'(q_item.digit);
    hex_acc = {acc_in[VALUE_BITS-5:0], q_item.digit};
    take_dec = 1'b0;
    take_hex = 1'b0;
    mode_next = mode;
    case (mode)
      MODE_START: begin
        if (q_item.is_minus) begin
          mode_next = MODE_NEG;
        end else if (q_item.is_zero) begin
          mode_next = MODE_ZERO;
        end else begin
          mode_next = MODE_POS;
          take_dec  = 1'b1;
        end
      end
      MODE_ZERO: begin
        if (q_item.is_x) begin
          mode_next = MODE_HEX;
        end else begin
          mode_next = MODE_POS;
          take_dec  = 1'b1;
        end
      end
      MODE_HEX: begin
        take_hex = 1'b1;
      end
      default: begin
        take_dec = 1'b1;
      end
    endcase
    acc_next     = acc_in;
    stopped_next = stop_in;
    if (!stop_in) begin
      if (take_dec) begin
        if (q_item.is_dec) begin
          acc_next = dec_acc;
        end else begin
          stopped_next = 1'b1;
        end
      end else if (take_hex) begin
        if (q_item.is_hex) begin
          acc_next = hex_acc;
        end else begin
          stopped_next = 1'b1;
        end
      end
    end
    result = (mode_next == MODE_NEG) ? -acc_next : acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      mode        <= MODE_START;
      stopped     <= 1'b0;
      value_valid <= 1'b0;
    end else begin
      if (pop && q_item.last) begin
        value_valid <= 1'b1;
      end else if (value_ready) begin
        value_valid <= 1'b0;
      end
      if (pop) begin
        if (q_item.last) begin
          acc     <= '0;
          mode    <= MODE_START;
          stopped <= 1'b0;
        end else begin
          acc     <= acc_next;
          mode    <= mode_next;
          stopped <= stopped_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.last) begin
      value <= 32'(result);
    end
  end

  `ANP_ASSERT_NEXT(a_last_restarts, pop && q_item.last, mode == MODE_START, "mode not restarted")
  `ANP_ASSERT_NEXT(a_result_source, !value_valid && !(pop && q_item.last), !value_valid, "spurious result")
  `ANP_ASSERT_IMPLY(a_stop_mode, stopped, mode != MODE_START && mode != MODE_ZERO, "stopped in prefix")
  `ANP_ASSERT_IMPLY(a_stall_blocks_pop, value_valid && !value_ready, !pop, "pop while result stalled")

endmodule

// ===== rtl/ascii_number_parser_core.sv =====
// ASCII number parser: streams one character per cycle and emits a signed
// integer on the character flagged last. A leading "0x" selects hex digits,
// a leading '-' a negated decimal number, anything else a positive decimal
// number; the first invalid character freezes the value and the rest of the
// string is ignored. Arithmetic wraps modulo 2^VALUE_BITS and the result is
// sign-extended or cut to 32 bits. One character is accepted every cycle
// while the result output is not stalled; the accumulator's shift-add is
// combinational. A result is presented once its last character has passed
// through the two-entry queue and the accumulator has popped it into the
// value register.
module ascii_number_parser_core #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        ch_valid,
  output logic        ch_ready,
  input  logic [7:0]  ch,
  input  logic        last,
  output logic        value_valid,
  input  logic        value_ready,
  output logic [31:0] value
);
  import anp_pkg::*;

  anp_item_t front_item;
  anp_item_t q_item;
  logic      q_valid;
  logic      q_pop;

  anp_front u_front (
    .ch   (ch),
    .last (last),
    .item (front_item)
  );

  anp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (ch_valid),
    .push_item (front_item),
    .not_full  (ch_ready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (q_item)
  );

  anp_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (q_pop),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .value       (value)
  );

endmodule
